/* hdl/rotation_matrix_to_quaternion_assert.svh */
// assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("rmq assertion failed");
`define RMQ_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("rmq assertion failed");
`else
`define RMQ_ASSERT_IMPL(label, clk, rst_n, a, c)
`define RMQ_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* hdl/rmq_pkg.sv */
// shared constants for the rotation matrix to quaternion block
package rmq_pkg;
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X = 2'd1;
  localparam logic [1:0] BR_Y = 2'd2;
  localparam logic [1:0] BR_Z = 2'd3;
  localparam int unsigned QW = 16;
  localparam int unsigned NW = 18;
  localparam int unsigned SW = 19;
endpackage

/* hdl/rotation_matrix_to_quaternion.sv */
// top level: rotation matrix to quaternion, fully pipelined
// channel  direction  ports
// in       input      in_valid, in_stall, in_m00..in_m22
// out      output     out_valid, out_stall, out_qx..out_qw, out_branch_used, out_degenerate
// one word per cycle while out_stall is low
// the path runs through the square root cells and then the division cells in a row
// out_stall freezes the whole row; in_stall equals out_stall
// synchronous active low reset clears valid bits only
`include "rotation_matrix_to_quaternion_assert.svh"
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   in_m00, in_m01, in_m02,
  input  logic signed [15:0]   in_m10, in_m11, in_m12,
  input  logic signed [15:0]   in_m20, in_m21, in_m22,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_qx, out_qy, out_qz, out_qw,
  output logic [1:0]           out_branch_used,
  output logic                 out_degenerate
);
  localparam int unsigned SWF = (FRAC_BITS + 2 > SW) ? FRAC_BITS + 2 : SW;
  localparam int unsigned RW0 = SWF + FRAC_BITS - 2;
  localparam int unsigned RW = RW0 + (RW0 % 2);
  localparam int unsigned NS = RW / 2;
  localparam int unsigned DW = NW + FRAC_BITS + 1;
  localparam int unsigned LAT = NS + DW + 2;
  localparam logic [DW-1:0] ONEQ = DW'(1) << FRAC_BITS;
  localparam logic [DW-1:0] PLIM = (ONEQ > DW'(32767)) ? DW'(32767) : ONEQ;
  localparam logic [DW-1:0] NLIM = (ONEQ > DW'(32768)) ? DW'(32768) : ONEQ;

  typedef struct packed {
    logic [1:0] br;
    logic [1:0] main;
    logic degen;
    logic [2:0] neg;
    logic [2:0][NW-1:0] mag;
  } side_t;

  logic en;
  assign en = !out_stall;
  assign in_stall = out_stall;

  logic [LAT:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-1:0], in_valid};
  end

  // stage 0: branch select
  logic signed [SWF-1:0] tr, s_nxt;
  logic signed [NW-1:0] n0, n1, n2;
  logic [1:0] br_nxt;
  always_comb begin
    tr = SWF'(in_m00) + SWF'(in_m11) + SWF'(in_m22);
    if (tr > 0) begin
      br_nxt = BR_TRACE; s_nxt = (SWF'(1) <<< FRAC_BITS) + tr;
      n0 = NW'(in_m21) - NW'(in_m12); n1 = NW'(in_m02) - NW'(in_m20);
      n2 = NW'(in_m10) - NW'(in_m01);
    end else if (in_m00 > in_m11 && in_m00 > in_m22) begin
      br_nxt = BR_X;
      s_nxt = (SWF'(1) <<< FRAC_BITS) + SWF'(in_m00) - SWF'(in_m11) - SWF'(in_m22);
      n0 = NW'(in_m21) - NW'(in_m12); n1 = NW'(in_m10) + NW'(in_m01);
      n2 = NW'(in_m02) + NW'(in_m20);
    end else if (in_m11 > in_m22) begin
      br_nxt = BR_Y;
      s_nxt = (SWF'(1) <<< FRAC_BITS) + SWF'(in_m11) - SWF'(in_m00) - SWF'(in_m22);
      n0 = NW'(in_m02) - NW'(in_m20); n1 = NW'(in_m10) + NW'(in_m01);
      n2 = NW'(in_m21) + NW'(in_m12);
    end else begin
      br_nxt = BR_Z;
      s_nxt = (SWF'(1) <<< FRAC_BITS) + SWF'(in_m22) - SWF'(in_m00) - SWF'(in_m11);
      n0 = NW'(in_m10) - NW'(in_m01); n1 = NW'(in_m02) + NW'(in_m20);
      n2 = NW'(in_m21) + NW'(in_m12);
    end
  end

  side_t sd0_nxt;
  logic [RW-1:0] rad_nxt;
  always_comb begin
    sd0_nxt.br = br_nxt;
    sd0_nxt.main = br_nxt;
    sd0_nxt.degen = (s_nxt <= 0);
    sd0_nxt.neg = {n2[NW-1], n1[NW-1], n0[NW-1]};
    sd0_nxt.mag[0] = n0[NW-1] ? -n0 : n0;
    sd0_nxt.mag[1] = n1[NW-1] ? -n1 : n1;
    sd0_nxt.mag[2] = n2[NW-1] ? -n2 : n2;
    rad_nxt = sd0_nxt.degen ? '0 : (RW'(s_nxt) << (FRAC_BITS - 2));
  end

  side_t sd_r [0:NS+DW+1];
  logic [RW-1:0] rem_c [0:NS];
  logic [RW-1:0] root_c [0:NS];
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= sd0_nxt;
      rem_c[0] <= rad_nxt;
      root_c[0] <= '0;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_sq
    rmq_sqrt_cell #(.RW(RW), .STEP(g)) u_c (
      .clk(clk), .en(en), .rem_in(rem_c[g]), .root_in(root_c[g]),
      .rem_r(rem_c[g+1]), .root_r(root_c[g+1]));
    always_ff @(posedge clk) if (en) sd_r[g+1] <= sd_r[g];
  end

  // division setup: numerator magnitude shifted plus half the divisor
  logic [DW-1:0] h, dvs;
  logic [2:0][DW-1:0] drem [0:DW];
  logic [2:0][DW-1:0] dq [0:DW];
  logic [DW-1:0] dd [0:DW];
  logic [DW-1:0] h_r [0:DW];
  side_t sdd;
  always_comb begin
    h = DW'(root_c[NS]);
    dvs = h << 2;
    sdd = sd_r[NS];
    sdd.degen = sd_r[NS].degen || (h == '0);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        drem[0][k] <= (DW'(sd_r[NS].mag[k]) << FRAC_BITS) + (dvs >> 1);
        dq[0][k] <= '0;
      end
      dd[0] <= dvs;
      h_r[0] <= h;
      sd_r[NS+1] <= sdd;
    end
  end

  for (genvar g = 0; g < DW; g++) begin : g_dv
    rmq_div_cell #(.DW(DW), .STEP(g)) u_c (
      .clk(clk), .en(en), .d(dd[g]), .rem_in(drem[g]), .q_in(dq[g]),
      .rem_r(drem[g+1]), .q_r(dq[g+1]));
    always_ff @(posedge clk) begin
      if (en) begin
        dd[g+1] <= dd[g];
        h_r[g+1] <= h_r[g];
        sd_r[NS+2+g] <= sd_r[NS+1+g];
      end
    end
  end

  // output stage: sign, clamp, route
  side_t sf;
  logic [3:0][QW-1:0] q_nxt;
  logic [QW-1:0] cm [0:3];
  logic [1:0] oi [0:2];
  always_comb begin
    sf = sd_r[NS+DW+1];
    cm[3] = (h_r[DW] > PLIM) ? QW'(PLIM) : QW'(h_r[DW]);
    for (int k = 0; k < 3; k++) begin
      logic [QW-1:0] m;
      logic [DW-1:0] lim;
      lim = sf.neg[k] ? NLIM : PLIM;
      m = (dq[DW][k] > lim) ? QW'(lim) : QW'(dq[DW][k]);
      cm[k] = sf.neg[k] ? -m : m;
    end
    unique case (sf.main)
      BR_TRACE: begin oi[0] = 2'd0; oi[1] = 2'd1; oi[2] = 2'd2; end
      BR_X: begin oi[0] = 2'd3; oi[1] = 2'd1; oi[2] = 2'd2; end
      BR_Y: begin oi[0] = 2'd3; oi[1] = 2'd0; oi[2] = 2'd2; end
      default: begin oi[0] = 2'd3; oi[1] = 2'd0; oi[2] = 2'd1; end
    endcase
    q_nxt = '0;
    q_nxt[(sf.main == BR_TRACE) ? 2'd3 : (sf.main - 2'd1)] = cm[3];
    for (int k = 0; k < 3; k++) q_nxt[oi[k]] = cm[k];
    if (sf.degen) q_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_qx <= q_nxt[0];
      out_qy <= q_nxt[1];
      out_qz <= q_nxt[2];
      out_qw <= q_nxt[3];
      out_branch_used <= sf.br;
      out_degenerate <= sf.degen;
    end
  end
  assign out_valid = v_r[LAT];

  `RMQ_ASSERT_IMPL(a_stall_tied, clk, rst_n, 1'b1, in_stall == out_stall)
  `RMQ_ASSERT_NEXT(a_hold, clk, rst_n, out_stall, v_r == $past(v_r))
  `RMQ_ASSERT_IMPL(a_degen_zero, clk, rst_n, out_valid && out_degenerate, out_qx == '0 && out_qw == '0)
endmodule

/* hdl/rmq_sqrt_cell.sv */
// one restoring square root step, radicand digit pair per stage
module rmq_sqrt_cell
  import rmq_pkg::*;
#(
  parameter int unsigned RW = 48,
  parameter int unsigned STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rem_in,
  input  logic [RW-1:0] root_in,
  output logic [RW-1:0] rem_r,
  output logic [RW-1:0] root_r
);
  localparam int unsigned SH = RW - 2 - 2*STEP;
  logic [RW-1:0] bitv, trial;
  always_comb begin
    bitv = {{(RW-1){1'b0}}, 1'b1} << SH;
    trial = root_in + bitv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem_r <= rem_in - trial;
        root_r <= (root_in >> 1) + bitv;
      end else begin
        rem_r <= rem_in;
        root_r <= root_in >> 1;
      end
    end
  end
endmodule

/* hdl/rmq_div_cell.sv */
// one restoring division step for three numerators sharing a divisor
module rmq_div_cell
  import rmq_pkg::*;
#(
  parameter int unsigned DW = 48,
  parameter int unsigned STEP = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW-1:0]    d,
  input  logic [2:0][DW-1:0] rem_in,
  input  logic [2:0][DW-1:0] q_in,
  output logic [2:0][DW-1:0] rem_r,
  output logic [2:0][DW-1:0] q_r
);
  localparam int unsigned SH = DW - 1 - STEP;
  logic [2*DW-1:0] ds;
  always_comb ds = {{DW{1'b0}}, d} << SH;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if ({{DW{1'b0}}, rem_in[k]} >= ds) begin
          rem_r[k] <= rem_in[k] - ds[DW-1:0];
          q_r[k] <= q_in[k] | ({{(DW-1){1'b0}}, 1'b1} << SH);
        end else begin
          rem_r[k] <= rem_in[k];
          q_r[k] <= q_in[k];
        end
      end
    end
  end
endmodule

/* verif/tb_rotation_matrix_to_quaternion.sv */
// testbench for the rotation matrix to quaternion block: directed table plus random matrices
`timescale 1ns / 100ps
module tb_rotation_matrix_to_quaternion
  import rmq_pkg::*;
();

  localparam int FRAC = 14;
  localparam int ONE = 1 << FRAC;
  localparam int N_RANDOM = 1000;

  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  typedef struct {
    logic signed [15:0] qx, qy, qz, qw;
    logic [1:0] branch;
    logic degen;
  } quat_t;

  typedef struct {
    matrix_t mat;
    bit has_quat;
    quat_t quat;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] in_m00 = 0, in_m01 = 0, in_m02 = 0;
  logic signed [15:0] in_m10 = 0, in_m11 = 0, in_m12 = 0;
  logic signed [15:0] in_m20 = 0, in_m21 = 0, in_m22 = 0;
  logic out_valid;
  logic out_stall = 1;
  logic signed [15:0] out_qx, out_qy, out_qz, out_qw;
  logic [1:0] out_branch_used;
  logic out_degenerate;

  quat_t pending_quats [$];
  row_t rows [$];
  int mismatches = 0;
  bit sending_done = 0;
  bit hold_long = 0;

  always #5 clk = ~clk;

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_m00(in_m00), .in_m01(in_m01), .in_m02(in_m02),
    .in_m10(in_m10), .in_m11(in_m11), .in_m12(in_m12),
    .in_m20(in_m20), .in_m21(in_m21), .in_m22(in_m22),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_qx(out_qx), .out_qy(out_qy), .out_qz(out_qz), .out_qw(out_qw),
    .out_branch_used(out_branch_used), .out_degenerate(out_degenerate)
  );

  function automatic longint isqrt(longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v)
        r = r + (longint'(1) << b);
    return r;
  endfunction

  function automatic logic signed [15:0] sat_q(longint v);
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint div_round(longint n, longint d);
    longint mag, q;
    mag = (n < 0 ? -n : n) << FRAC;
    q = (mag + (d >> 1)) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t a);
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    longint tr, s, h, d, n0, n1, n2;
    longint q [4];
    int main_i, i0, i1, i2;
    quat_t r;
    m00 = longint'(a.m[0]); m01 = longint'(a.m[1]); m02 = longint'(a.m[2]);
    m10 = longint'(a.m[3]); m11 = longint'(a.m[4]); m12 = longint'(a.m[5]);
    m20 = longint'(a.m[6]); m21 = longint'(a.m[7]); m22 = longint'(a.m[8]);
    tr = m00 + m11 + m22;
    q = '{0, 0, 0, 0};
    if (tr > 0) begin
      r.branch = BR_TRACE; s = ONE + tr;
      main_i = 3; i0 = 0; i1 = 1; i2 = 2;
      n0 = m21 - m12; n1 = m02 - m20; n2 = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      r.branch = BR_X; s = ONE + m00 - m11 - m22;
      main_i = 0; i0 = 3; i1 = 1; i2 = 2;
      n0 = m21 - m12; n1 = m10 + m01; n2 = m02 + m20;
    end else if (m11 > m22) begin
      r.branch = BR_Y; s = ONE + m11 - m00 - m22;
      main_i = 1; i0 = 3; i1 = 0; i2 = 2;
      n0 = m02 - m20; n1 = m10 + m01; n2 = m21 + m12;
    end else begin
      r.branch = BR_Z; s = ONE + m22 - m00 - m11;
      main_i = 2; i0 = 3; i1 = 0; i2 = 1;
      n0 = m10 - m01; n1 = m02 + m20; n2 = m21 + m12;
    end
    r.degen = 1;
    if (s > 0) begin
      h = isqrt(s << (FRAC - 2));
      if (h != 0) begin
        r.degen = 0;
        d = 4 * h;
        q[main_i] = longint'(sat_q(h));
        q[i0] = longint'(sat_q(div_round(n0, d)));
        q[i1] = longint'(sat_q(div_round(n1, d)));
        q[i2] = longint'(sat_q(div_round(n2, d)));
      end
    end
    r.qx = q[0][15:0]; r.qy = q[1][15:0]; r.qz = q[2][15:0]; r.qw = q[3][15:0];
    return r;
  endfunction

  function automatic matrix_t mk(int a0, int a1, int a2, int a3, int a4,
                                 int a5, int a6, int a7, int a8);
    matrix_t x;
    x.m = '{16'(a0), 16'(a1), 16'(a2), 16'(a3), 16'(a4), 16'(a5), 16'(a6),
            16'(a7), 16'(a8)};
    return x;
  endfunction

  function automatic quat_t qk(int x, int y, int z, int w, logic [1:0] b, logic dg);
    quat_t r;
    r.qx = 16'(x); r.qy = 16'(y); r.qz = 16'(z); r.qw = 16'(w);
    r.branch = b; r.degen = dg;
    return r;
  endfunction

  function automatic row_t plain(matrix_t a);
    row_t r;
    r.mat = a; r.has_quat = 0;
    return r;
  endfunction

  function automatic row_t typed(matrix_t a, quat_t q);
    row_t r;
    r.mat = a; r.has_quat = 1; r.quat = q;
    return r;
  endfunction

  function automatic int pick_entry();
    case ($urandom_range(0, 5))
      0: return ONE;
      1: return -ONE;
      2: return int'($urandom_range(0, 65535)) - 32768;
      default: return int'($urandom_range(0, 2 * ONE)) - ONE;
    endcase
  endfunction

  function automatic matrix_t random_rotation();
    matrix_t x;
    int ax, c, s, p;
    // plane rotation about a random axis, with an optional diagonal sign flip and noise
    ax = int'($urandom_range(0, 2));
    c = int'($urandom_range(0, 2 * ONE)) - ONE;
    s = int'($urandom_range(0, 2 * ONE)) - ONE;
    x = mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
    case (ax)
      0: x = mk(ONE, 0, 0, 0, c, -s, 0, s, c);
      1: x = mk(c, 0, s, 0, ONE, 0, -s, 0, c);
      default: x = mk(c, -s, 0, s, c, 0, 0, 0, ONE);
    endcase
    if ($urandom_range(0, 1)) begin
      p = int'($urandom_range(0, 2)) * 4;
      x.m[p] = -x.m[p];
    end
    for (int i = 0; i < 9; i++)
      x.m[i] = 16'(int'(x.m[i]) + int'($urandom_range(0, 64)) - 32);
    return x;
  endfunction

  task automatic send_matrix(matrix_t a);
    in_valid <= 1;
    {in_m00, in_m01, in_m02} <= {a.m[0], a.m[1], a.m[2]};
    {in_m10, in_m11, in_m12} <= {a.m[3], a.m[4], a.m[5]};
    {in_m20, in_m21, in_m22} <= {a.m[6], a.m[7], a.m[8]};
    do @(posedge clk); while (in_stall);
    pending_quats.push_back(matrix_to_quat(a));
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) g = 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    int drained;
    matrix_t a;
    rows.push_back(typed(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE),
                         qk(0, 0, 0, ONE, BR_TRACE, 0)));
    rows.push_back(typed(mk(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE),
                         qk(ONE, 0, 0, 0, BR_X, 0)));
    rows.push_back(typed(mk(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE),
                         qk(0, ONE, 0, 0, BR_Y, 0)));
    rows.push_back(typed(mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE),
                         qk(0, 0, ONE, 0, BR_Z, 0)));
    rows.push_back(typed(mk(0, 0, 0, 0, 0, 0, 0, 0, 0),
                         qk(0, 0, ONE / 2, 0, BR_Z, 0)));
    rows.push_back(plain(mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE)));
    rows.push_back(plain(mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768)));
    rows.push_back(plain(mk(32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 32767, 32767)));
    rows.push_back(plain(mk(-32768, 32767, -32768, 32767, -32768, 32767,
                            -32768, 32767, 1)));
    rows.push_back(plain(mk(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE)));
    rows.push_back(plain(mk(0, 0, ONE, 0, ONE, 0, -ONE, 0, 0)));
    rows.push_back(plain(mk(ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0)));
    rows.push_back(plain(mk(-16000, 32767, -32768, -32768, -16383, 32767,
                            32767, -32768, -16384)));
    rows.push_back(plain(mk(-ONE, 5, 9, -7, -ONE, 3, 2, -1, -ONE + 1)));
    rows.push_back(plain(mk(-8000, 1, 1, 1, -8000, 1, 1, 1, -8000)));
    rows.push_back(plain(mk(-ONE, 20000, 20000, 20000, -ONE, 20000,
                            20000, 20000, -ONE + 2)));
    rows.push_back(plain(mk(-16385, 0, 0, 0, -16384, 0, 0, 0, 1)));

    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_matrix(rows[i].mat);
      if (rows[i].has_quat) pending_quats[$] = rows[i].quat;
      if (i % 3 == 0) idle_gap();
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      if ($urandom_range(0, 3) == 0)
        for (int i = 0; i < 9; i++) a.m[i] = 16'(pick_entry());
      else
        a = random_rotation();
      if (k == 300) hold_long = 1;
      send_matrix(a);
      if (k < 150 || k > 500) idle_gap();
    end
    in_valid <= 0;
    sending_done = 1;
    drained = 0;
    while (pending_quats.size() != 0 && drained < 20000) begin
      @(posedge clk);
      drained++;
    end
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_quats.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // result side stall pattern
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        hold_long = 0;
        out_stall <= 1;
        repeat (200) @(posedge clk);
      end
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) g = 0;
      if (g > 0) begin
        out_stall <= 1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    quat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %0d %0d %0d %0d",
                                       out_qx, out_qy, out_qz, out_qw);
      end else begin
        e = pending_quats.pop_front();
        if (out_qx !== e.qx || out_qy !== e.qy || out_qz !== e.qz ||
            out_qw !== e.qw || out_branch_used !== e.branch ||
            out_degenerate !== e.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("exp %0d %0d %0d %0d b%0d d%0d got %0d %0d %0d %0d b%0d d%0d",
                     e.qx, e.qy, e.qz, e.qw, e.branch, e.degen, out_qx, out_qy,
                     out_qz, out_qw, out_branch_used, out_degenerate);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
